### hdl/ubdc_pkg.sv
package ubdc_pkg;

   localparam int BAUD_W        = 24;
   localparam int CLK_W         = 28;
   localparam int NUM_W         = 33;
   localparam int DEN_W         = 26;
   localparam int MANT_W        = 12;
   localparam int FRAC_W        = 4;
   localparam int WORD_W        = 16;
   localparam int CSR_ADDR_W    = 2;
   localparam int RSP_TDATA_W   = 40;

   localparam int STEPS_PER_STAGE = 3;
   localparam int DIV_STAGES      = NUM_W / STEPS_PER_STAGE;

   localparam logic [CSR_ADDR_W-1:0] CSR_PCLK_LOW_BUS_HZ  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PCLK_HIGH_BUS_HZ = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_OVERSAMPLE_BY_8  = 2'd2;

   localparam logic [CLK_W-1:0] PCLK_RESET = 28'd16000000;

   localparam logic [MANT_W-1:0] MANT_MAX = 12'd4095;
   // quotient at or above this value gives a mantissa above MANT_MAX
   localparam logic [NUM_W-1:0] QUOT_LIMIT = 33'd409600;
   // floor(2^24/100): exact floor(q/100) with one correction for q < 409600
   localparam logic [17:0] RECIP_W = 18'd167772;
   // floor(2^31/100): used on the folded remainder value below 2^23
   localparam logic [24:0] RECIP_R = 25'd21474836;
   // ceil(2^16/100): exact floor(x/100) for even x below 1650
   localparam logic [9:0]  RECIP_F = 10'd656;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] denom;
      logic             by8;
      logic             zero;
   } div_type;

endpackage

### hdl/ubdc_div_stage.sv
module ubdc_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ubdc_pkg::div_type in_data,
   output logic              out_valid,
   output ubdc_pkg::div_type out_data
);
   import ubdc_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   always_comb begin
      logic [DEN_W:0] part;
      data_in = in_data;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
         part = {data_in.rem, data_in.num[NUM_W-1]};
         data_in.num = {data_in.num[NUM_W-2:0], 1'b0};
         if (part >= {1'b0, data_in.denom}) begin
            part = part - {1'b0, data_in.denom};
            data_in.num[0] = 1'b1;
         end
         data_in.rem = part[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/ubdc_post.sv
module ubdc_post (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [ubdc_pkg::NUM_W-1:0]  quot,
   input  logic                        by8,
   input  logic                        zero,
   output logic                        out_valid,
   output logic [ubdc_pkg::WORD_W-1:0] divisor_word,
   output logic [ubdc_pkg::MANT_W-1:0] mantissa,
   output logic [ubdc_pkg::FRAC_W-1:0] fraction,
   output logic                        range_error
);
   import ubdc_pkg::*;

   logic [3:0] valid_ff;

   // stage 1: saturation check and fold of quotient mod 100
   logic        sat1_ff, by8_1_ff, zero1_ff;
   logic [18:0] q1_ff;
   logic [22:0] t1_ff;
   logic [22:0] t1_in;

   // stage 2: reciprocal products
   logic        sat2_ff, by8_2_ff, zero2_ff;
   logic [18:0] q2_ff;
   logic [22:0] t2_ff;
   logic [36:0] pw2_ff, pw2_in;
   logic [47:0] pr2_ff, pr2_in;

   // stage 3: corrected mantissa and remainder
   logic        sat3_ff, by8_3_ff, zero3_ff;
   logic [MANT_W-1:0] mant3_ff, mant3_in;
   logic [6:0]  rem3_ff, rem3_in;

   // stage 4: output registers
   logic [MANT_W-1:0] mant4_ff, mant4_in;
   logic [FRAC_W-1:0] frac4_ff, frac4_in;
   logic              err4_ff, err4_in;

   assign t1_in = ({6'b0, quot[NUM_W-1:16]} * 23'd36) + {7'b0, quot[15:0]};

   assign pw2_in = 37'(q1_ff) * 37'(RECIP_W);
   assign pr2_in = 48'(t1_ff) * 48'(RECIP_R);

   always_comb begin
      logic [MANT_W-1:0] w_est;
      logic [18:0]       rw;
      logic [16:0]       r_est;
      logic [22:0]       rt;
      w_est = pw2_ff[35:24];
      rw    = q2_ff - (19'(w_est) * 19'd100);
      r_est = pr2_ff[47:31];
      rt    = t2_ff - (23'(r_est) * 23'd100);
      if (sat2_ff) begin
         mant3_in = MANT_MAX;
      end else if (rw >= 19'd100) begin
         mant3_in = w_est + 12'd1;
      end else begin
         mant3_in = w_est;
      end
      if (rt >= 23'd100) begin
         rt = rt - 23'd100;
      end
      rem3_in = rt[6:0];
   end

   always_comb begin
      logic [10:0] x;
      logic [20:0] p;
      if (by8_3_ff) begin
         x = {1'b0, rem3_ff, 3'b0} + 11'd50;
      end else begin
         x = {rem3_ff, 4'b0} + 11'd50;
      end
      p = 21'(x) * 21'(RECIP_F);
      if (zero3_ff) begin
         mant4_in = MANT_MAX;
         frac4_in = '0;
         err4_in  = 1'b1;
      end else begin
         mant4_in = mant3_ff;
         frac4_in = by8_3_ff ? {1'b0, p[18:16]} : p[19:16];
         err4_in  = sat3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat1_ff  <= (quot >= QUOT_LIMIT);
         by8_1_ff <= by8;
         zero1_ff <= zero;
         q1_ff    <= quot[18:0];
         t1_ff    <= t1_in;

         sat2_ff  <= sat1_ff;
         by8_2_ff <= by8_1_ff;
         zero2_ff <= zero1_ff;
         q2_ff    <= q1_ff;
         t2_ff    <= t1_ff;
         pw2_ff   <= pw2_in;
         pr2_ff   <= pr2_in;

         sat3_ff  <= sat2_ff;
         by8_3_ff <= by8_2_ff;
         zero3_ff <= zero2_ff;
         mant3_ff <= mant3_in;
         rem3_ff  <= rem3_in;

         mant4_ff <= mant4_in;
         frac4_ff <= frac4_in;
         err4_ff  <= err4_in;
      end
   end

   assign out_valid    = valid_ff[3];
   assign mantissa     = mant4_ff;
   assign fraction     = frac4_ff;
   assign range_error  = err4_ff;
   assign divisor_word = {mant4_ff, frac4_ff};

endmodule

### hdl/uart_baud_divisor_calc_unit.sv
// UART fractional baud-rate divisor calculator.
// req channel: tdata[23:0] is the baud rate, tuser selects the faster bus clock.
// rsp channel: one transaction per request, in order, with divisor word,
// mantissa, fraction and range error packed in tdata.
// csr port: index 0 slow bus clock, 1 fast bus clock, 2 oversample-by-8 flag;
// write only while no request is in flight.
// An accepted request passes through one input register, 11 divider stages
// of 3 restoring steps each (33-bit quotient), then 4 stages of reciprocal
// multiply, correction and rounding before rsp_tvalid.
// Throughput is one transaction per cycle while the output is not stalled.
// The whole pipeline advances together; when rsp_tvalid is high and
// rsp_tready is low every stage holds and req_tready drops, so nothing is
// lost or repeated.
// Reset clears all valid bits and loads both clocks with 16 MHz and
// oversampling by 16.
module uart_baud_divisor_calc_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [23:0] baud_rate
   input  logic [ubdc_pkg::BAUD_W-1:0]      req_tdata,
   // [0] use_high_bus
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [15:0] divisor_word, [27:16] mantissa, [31:28] fraction, [32] range_error
   output logic [ubdc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [ubdc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ubdc_pkg::CLK_W-1:0]       csr_wdata
);
   import ubdc_pkg::*;

   logic [CLK_W-1:0] pclk_low_ff, pclk_high_ff;
   logic             by8_ff;
   logic             en;

   logic    div_valid [DIV_STAGES+1];
   div_type div_data  [DIV_STAGES+1];

   logic    in_valid_ff;
   div_type in_data_ff, in_data_in;

   logic [WORD_W-1:0] divisor_word;
   logic [MANT_W-1:0] mantissa;
   logic [FRAC_W-1:0] fraction;
   logic              range_error;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         pclk_low_ff  <= PCLK_RESET;
         pclk_high_ff <= PCLK_RESET;
         by8_ff       <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PCLK_LOW_BUS_HZ:  pclk_low_ff  <= csr_wdata;
            CSR_PCLK_HIGH_BUS_HZ: pclk_high_ff <= csr_wdata;
            CSR_OVERSAMPLE_BY_8:  by8_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [NUM_W-1:0] clk_ext;
      clk_ext = NUM_W'(req_tuser ? pclk_high_ff : pclk_low_ff);
      in_data_in.rem   = '0;
      in_data_in.num   = (clk_ext << 4) + (clk_ext << 3) + clk_ext;
      in_data_in.denom = by8_ff ? {1'b0, req_tdata, 1'b0} : {req_tdata, 2'b0};
      in_data_in.by8   = by8_ff;
      in_data_in.zero  = (req_tdata == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_data_ff <= in_data_in;
      end
   end

   assign div_valid[0] = in_valid_ff;
   assign div_data[0]  = in_data_ff;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      ubdc_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[s]),
         .in_data   (div_data[s]),
         .out_valid (div_valid[s+1]),
         .out_data  (div_data[s+1])
      );
   end

   ubdc_post u_post (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (div_valid[DIV_STAGES]),
      .quot         (div_data[DIV_STAGES].num),
      .by8          (div_data[DIV_STAGES].by8),
      .zero         (div_data[DIV_STAGES].zero),
      .out_valid    (rsp_tvalid),
      .divisor_word (divisor_word),
      .mantissa     (mantissa),
      .fraction     (fraction),
      .range_error  (range_error)
   );

   assign rsp_tdata = {7'b0, range_error, fraction, mantissa, divisor_word};

endmodule
